### hw/rtl/phcm_pkg.sv
package phcm_pkg;

  localparam int MAX_PATTERN_NIBBLES_DEF = 32;
  localparam int POSITION_BITS_DEF = 16;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS = 64;
  localparam int WINDOW_BITS = 16;
  localparam int LENGTH_BITS = 6;
  // wide enough for any clamped length up to 64 nibbles
  localparam int LEN_CMP_BITS = 7;
  // nibbles held in each pattern register
  localparam int PATTERN_REG_NIBBLES = 16;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_WINDOW_START = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_WINDOW_END = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PATTERN_LOW = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PATTERN_HIGH = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PATTERN_LENGTH = 3'd4;

  typedef logic [3:0] nibble_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

endpackage

### hw/rtl/phcm_cell.sv
module phcm_cell (
  input  logic                clk,
  input  logic                rst,
  input  phcm_pkg::cell_ctl_t ctl,
  input  phcm_pkg::nibble_t   hi,
  input  phcm_pkg::nibble_t   lo,
  input  phcm_pkg::nibble_t   pat,
  input  logic                tail,
  input  logic                m_prev,
  input  logic                mid_prev,
  output logic                m,
  output logic                mid,
  output logic                hit
);

  logic m_next;

  // prefix through this cell matches after the high nibble, then after the low nibble
  assign mid    = m_prev & (hi == pat);
  assign m_next = mid_prev & (lo == pat);
  assign hit    = tail & (mid | m_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      m <= 1'b0;
    end else if (ctl.clear) begin
      m <= 1'b0;
    end else if (ctl.shift) begin
      m <= m_next;
    end
  end

endmodule

### hw/rtl/packet_hex_content_match.sv
// Nibble pattern search over a byte window of each packet.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high. Index 0 window_start, 1 window_end (0 = to packet end),
// 2 pattern nibbles 0..15, 3 pattern nibbles 16..31, 4 pattern length.
// Write only while no packet is in progress.
// Input: one packet byte per beat on in_valid/in_ready, last_byte on the
// final beat of a packet. One byte per cycle is sustained while in_ready is high: a row of match
// cells, one per pattern nibble, advances both nibbles of a byte each cycle.
// Output: one beat with matched per packet, registered; when no earlier result
// waits, it is shown the cycle after the last byte is taken.
// A two-entry result queue sits before the output; bytes keep flowing while
// a result waits, and in_ready drops only when two results are held.
// Reset clears the registers, the packet state and the result queue.
module packet_hex_content_match #(
  parameter int MAX_PATTERN_NIBBLES = phcm_pkg::MAX_PATTERN_NIBBLES_DEF,
  parameter int POSITION_BITS = phcm_pkg::POSITION_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [phcm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [phcm_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [7:0]                          packet_byte,
  input  logic                                last_byte,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                matched
);

  localparam int CmpBits = (POSITION_BITS > phcm_pkg::WINDOW_BITS) ?
                           POSITION_BITS : phcm_pkg::WINDOW_BITS;
  localparam logic [POSITION_BITS-1:0] PosMax = '1;
  localparam logic [phcm_pkg::LEN_CMP_BITS-1:0] MaxLen =
    phcm_pkg::LEN_CMP_BITS'(MAX_PATTERN_NIBBLES);

  logic [phcm_pkg::WINDOW_BITS-1:0]   window_start;
  logic [phcm_pkg::WINDOW_BITS-1:0]   window_end;
  logic [phcm_pkg::CFG_DATA_BITS-1:0] pattern_low;
  logic [phcm_pkg::CFG_DATA_BITS-1:0] pattern_high;
  logic [phcm_pkg::LENGTH_BITS-1:0]   pattern_length;

  logic [POSITION_BITS-1:0]          byte_position;
  logic                              found;
  logic [phcm_pkg::LEN_CMP_BITS-1:0] len_wide;
  logic [phcm_pkg::LEN_CMP_BITS-1:0] len_eff;
  logic [CmpBits-1:0]                pos_ext;
  logic                              in_window;
  logic                              in_accept;
  logic                              push;
  logic                              pop;
  logic                              hit_now;
  logic                              result;
  phcm_pkg::cell_ctl_t               ctl;
  phcm_pkg::nibble_t                 hi;
  phcm_pkg::nibble_t                 lo;

  logic [MAX_PATTERN_NIBBLES-1:0] m;
  logic [MAX_PATTERN_NIBBLES-1:0] mid;
  logic [MAX_PATTERN_NIBBLES-1:0] hit;
  logic [MAX_PATTERN_NIBBLES-1:0] tail;
  phcm_pkg::nibble_t              pat [MAX_PATTERN_NIBBLES];

  logic skid_valid;
  logic skid_matched;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_start   <= '0;
      window_end     <= '0;
      pattern_low    <= '0;
      pattern_high   <= '0;
      pattern_length <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        phcm_pkg::CFG_WINDOW_START:   window_start <= cfg_data[phcm_pkg::WINDOW_BITS-1:0];
        phcm_pkg::CFG_WINDOW_END:     window_end <= cfg_data[phcm_pkg::WINDOW_BITS-1:0];
        phcm_pkg::CFG_PATTERN_LOW:    pattern_low <= cfg_data;
        phcm_pkg::CFG_PATTERN_HIGH:   pattern_high <= cfg_data;
        phcm_pkg::CFG_PATTERN_LENGTH: pattern_length <= cfg_data[phcm_pkg::LENGTH_BITS-1:0];
        default: ;
      endcase
    end
  end

  // clamp the length to the number of cells
  assign len_wide = phcm_pkg::LEN_CMP_BITS'(pattern_length);
  assign len_eff  = (len_wide > MaxLen) ? MaxLen : len_wide;

  assign pos_ext   = CmpBits'(byte_position);
  assign in_window = (pos_ext >= CmpBits'(window_start)) &&
                     ((window_end == '0) || (pos_ext < CmpBits'(window_end)));

  assign in_ready  = !skid_valid;
  assign in_accept = in_valid && in_ready;
  assign ctl.shift = in_accept && in_window;
  assign ctl.clear = in_accept && last_byte;
  assign hi        = packet_byte[7:4];
  assign lo        = packet_byte[3:0];

  for (genvar k = 0; k < MAX_PATTERN_NIBBLES; k++) begin : g_cell
    logic m_prev;
    logic mid_prev;

    if (k < phcm_pkg::PATTERN_REG_NIBBLES) begin : g_low
      assign pat[k] = pattern_low[phcm_pkg::CFG_DATA_BITS-1-4*k -: 4];
    end else if (k < 2 * phcm_pkg::PATTERN_REG_NIBBLES) begin : g_high
      assign pat[k] = pattern_high[phcm_pkg::CFG_DATA_BITS-1-
                                   4*(k-phcm_pkg::PATTERN_REG_NIBBLES) -: 4];
    end else begin : g_zero
      assign pat[k] = '0;
    end

    // the empty prefix always matches ahead of the first cell
    if (k == 0) begin : g_head
      assign m_prev   = 1'b1;
      assign mid_prev = 1'b1;
    end else begin : g_link
      assign m_prev   = m[k-1];
      assign mid_prev = mid[k-1];
    end

    assign tail[k] = (len_eff == phcm_pkg::LEN_CMP_BITS'(k + 1));

    phcm_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .hi       (hi),
      .lo       (lo),
      .pat      (pat[k]),
      .tail     (tail[k]),
      .m_prev   (m_prev),
      .mid_prev (mid_prev),
      .m        (m[k]),
      .mid      (mid[k]),
      .hit      (hit[k])
    );
  end

  assign hit_now = ctl.shift && (|hit);
  assign result  = found || hit_now || (len_eff == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      found         <= 1'b0;
    end else if (in_accept) begin
      if (last_byte) begin
        byte_position <= '0;
        found         <= 1'b0;
      end else begin
        if (byte_position != PosMax) begin
          byte_position <= byte_position + 1'b1;
        end
        found <= found || hit_now;
      end
    end
  end

  // result queue: output register plus one skid entry
  assign push = in_accept && last_byte;
  assign pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (pop) begin
        if (skid_valid) begin
          matched <= skid_matched;
          if (push) begin
            skid_matched <= result;
          end else begin
            skid_valid <= 1'b0;
          end
        end else if (push) begin
          matched <= result;
        end else begin
          out_valid <= 1'b0;
        end
      end else if (push) begin
        if (!out_valid) begin
          matched   <= result;
          out_valid <= 1'b1;
        end else begin
          skid_matched <= result;
          skid_valid   <= 1'b1;
        end
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held without an output beat");

  a_packet_cleared: assert property (@(posedge clk) disable iff (rst)
    (in_accept && last_byte) |=> (!found && byte_position == '0 && m == '0))
    else $error("packet state not cleared after last byte");

  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    (push && !out_valid) |=> (out_valid && matched == $past(result)))
    else $error("result beat not presented");

  a_queue_drains: assert property (@(posedge clk) disable iff (rst)
    (pop && !skid_valid && !push) |=> !out_valid)
    else $error("output beat repeated");
`endif

endmodule

### bench/match_result_checker.sv
module match_result_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [phcm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [phcm_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic [7:0]                          packet_byte,
  input  logic                                last_byte,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic                                matched,
  output int                                  mismatches,
  output int                                  results_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NIBS = phcm_pkg::MAX_PATTERN_NIBBLES_DEF;

  logic [phcm_pkg::WINDOW_BITS-1:0]       win_start;
  logic [phcm_pkg::WINDOW_BITS-1:0]       win_end;
  logic [63:0]                            pat_lo;
  logic [63:0]                            pat_hi;
  logic [phcm_pkg::LENGTH_BITS-1:0]       pat_len;
  logic [phcm_pkg::POSITION_BITS_DEF-1:0] byte_pos;
  phcm_pkg::nibble_t                      hist [NIBS];
  int                                     nib_count;
  bit                                     found;
  bit                                     match_expect [$];
  int                                     error_total;

  function automatic int used_length();
    return (int'(pat_len) > NIBS) ? NIBS : int'(pat_len);
  endfunction

  function automatic phcm_pkg::nibble_t pattern_nibble(input int k);
    if (k < phcm_pkg::PATTERN_REG_NIBBLES) return pat_lo[63 - 4 * k -: 4];
    return pat_hi[63 - 4 * (k - phcm_pkg::PATTERN_REG_NIBBLES) -: 4];
  endfunction

  task automatic clear_packet();
    byte_pos = '0;
    for (int k = 0; k < NIBS; k++) hist[k] = '0;
    nib_count = 0;
    found = 1'b0;
  endtask

  // hist[0] is the newest nibble, so the pattern start sits at hist[len-1]
  task automatic take_nibble(input phcm_pkg::nibble_t n);
    int len;
    bit hit;
    for (int k = NIBS - 1; k > 0; k--) hist[k] = hist[k-1];
    hist[0] = n;
    if (nib_count < NIBS) nib_count++;
    len = used_length();
    if (len == 0 || nib_count < len) return;
    hit = 1'b1;
    for (int k = 0; k < len; k++) begin
      if (hist[len - 1 - k] != pattern_nibble(k)) hit = 1'b0;
    end
    if (hit) found = 1'b1;
  endtask

  task automatic take_byte(input logic [7:0] b, input logic l);
    if (byte_pos >= win_start && (win_end == '0 || byte_pos < win_end)) begin
      take_nibble(b[7:4]);
      take_nibble(b[3:0]);
    end
    // position saturates on very long packets
    if (byte_pos != '1) byte_pos = byte_pos + 1'b1;
    if (l) begin
      match_expect.push_back(found || used_length() == 0);
      clear_packet();
    end
  endtask

  always @(posedge clk) begin
    bit want;
    if (rst) begin
      win_start = '0;
      win_end = '0;
      pat_lo = '0;
      pat_hi = '0;
      pat_len = '0;
      clear_packet();
      match_expect.delete();
      error_total = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          phcm_pkg::CFG_WINDOW_START: win_start = cfg_data[phcm_pkg::WINDOW_BITS-1:0];
          phcm_pkg::CFG_WINDOW_END: win_end = cfg_data[phcm_pkg::WINDOW_BITS-1:0];
          phcm_pkg::CFG_PATTERN_LOW: pat_lo = cfg_data;
          phcm_pkg::CFG_PATTERN_HIGH: pat_hi = cfg_data;
          phcm_pkg::CFG_PATTERN_LENGTH: pat_len = cfg_data[phcm_pkg::LENGTH_BITS-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) take_byte(packet_byte, last_byte);
      if (out_valid && out_ready) begin
        if (match_expect.size() == 0) begin
          $error("matched: no result expected, actual %0b", matched);
          error_total++;
        end else begin
          want = match_expect.pop_front();
          if (matched !== want) begin
            $error("matched: expected %0b, actual %0b", want, matched);
            error_total++;
          end
        end
      end
    end
    mismatches <= error_total;
    results_pending <= match_expect.size();
  end

endmodule

### bench/packet_hex_content_match_tb.sv
module packet_hex_content_match_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // index with no register behind it
  localparam logic [phcm_pkg::CFG_INDEX_BITS-1:0] CFG_SPARE = 3'd7;
  localparam int CYCLE_LIMIT = 500000;
  localparam int RANDOM_BYTES = 1050;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int PRESSURE_PHASE = 6;
  localparam int POS_MAX = 65535;

  logic                                clk;
  logic                                rst;
  logic                                cfg_valid;
  logic                                cfg_ready;
  logic [phcm_pkg::CFG_INDEX_BITS-1:0] cfg_index;
  logic [phcm_pkg::CFG_DATA_BITS-1:0]  cfg_data;
  logic                                in_valid;
  logic                                in_ready;
  logic [7:0]                          packet_byte;
  logic                                last_byte;
  logic                                out_valid;
  logic                                out_ready;
  logic                                matched;
  int                                  mismatches;
  int                                  results_pending;

  // register values as last written, used to shape packets
  int          cur_start;
  int          cur_end;
  int          cur_len;
  logic [63:0] cur_lo;
  logic [63:0] cur_hi;

  logic [7:0] pkt_bytes [$];
  int         tx_pct;
  int         rx_pct;
  bit         long_hold_req;
  int         bytes_sent;
  int         cycles;

  packet_hex_content_match dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .packet_byte(packet_byte),
    .last_byte(last_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .matched(matched)
  );

  match_result_checker match_check (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .packet_byte(packet_byte),
    .last_byte(last_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .matched(matched),
    .mismatches(mismatches),
    .results_pending(results_pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result side: short random stalls, plus one long hold on request
  initial begin
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end else if (rx_pct > 0 && $urandom_range(0, 99) < rx_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  function automatic phcm_pkg::nibble_t pattern_nib(input int k);
    if (k < phcm_pkg::PATTERN_REG_NIBBLES) return cur_lo[63 - 4 * k -: 4];
    return cur_hi[63 - 4 * (k - phcm_pkg::PATTERN_REG_NIBBLES) -: 4];
  endfunction

  // value in the low bits, random junk or zeros above
  function automatic logic [63:0] padded(input int unsigned v, input int bits);
    logic [63:0] d;
    d = ($urandom_range(0, 1) == 1) ? {$urandom(), $urandom()} : 64'd0;
    for (int i = 0; i < bits; i++) d[i] = v[i];
    return d;
  endfunction

  // leaves cfg_valid high; caller lowers it after the last write
  task automatic write_reg(input logic [phcm_pkg::CFG_INDEX_BITS-1:0] idx,
                           input logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      phcm_pkg::CFG_WINDOW_START: cur_start = int'(data[phcm_pkg::WINDOW_BITS-1:0]);
      phcm_pkg::CFG_WINDOW_END: cur_end = int'(data[phcm_pkg::WINDOW_BITS-1:0]);
      phcm_pkg::CFG_PATTERN_LOW: cur_lo = data;
      phcm_pkg::CFG_PATTERN_HIGH: cur_hi = data;
      phcm_pkg::CFG_PATTERN_LENGTH: cur_len = int'(data[phcm_pkg::LENGTH_BITS-1:0]);
      default: ;
    endcase
  endtask

  task automatic send_byte(input logic [7:0] b, input logic l);
    if (tx_pct > 0 && $urandom_range(0, 99) < tx_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    packet_byte <= b;
    last_byte <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_packet();
    foreach (pkt_bytes[i]) send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
  endtask

  // stop offering beats and wait until every result is back
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic build_packet(input int plen, input bit plant, input bit spoil);
    int eff;
    int stop;
    int room;
    int at;
    int bad;
    bit mix;
    phcm_pkg::nibble_t nib;
    logic [7:0] b;
    eff = (cur_len > phcm_pkg::MAX_PATTERN_NIBBLES_DEF) ?
          phcm_pkg::MAX_PATTERN_NIBBLES_DEF : cur_len;
    // background made of pattern nibbles gives many partial matches
    mix = eff > 0 && $urandom_range(0, 2) == 0;
    pkt_bytes.delete();
    for (int i = 0; i < plen; i++) begin
      if (mix) b = {pattern_nib(int'($urandom_range(0, eff - 1))),
                    pattern_nib(int'($urandom_range(0, eff - 1)))};
      else b = 8'($urandom_range(0, 255));
      pkt_bytes.push_back(b);
    end
    stop = (cur_end == 0 || cur_end > plen) ? plen : cur_end;
    room = 2 * (stop - cur_start);
    if (plant && eff > 0 && room >= eff) begin
      at = 2 * cur_start + int'($urandom_range(0, room - eff));
      bad = spoil ? int'($urandom_range(0, eff - 1)) : -1;
      for (int k = 0; k < eff; k++) begin
        nib = pattern_nib(k);
        if (k == bad) nib = nib ^ 4'($urandom_range(1, 15));
        b = pkt_bytes[(at + k) / 2];
        if ((at + k) % 2 == 0) b[7:4] = nib;
        else b[3:0] = nib;
        pkt_bytes[(at + k) / 2] = b;
      end
    end
  endtask

  task automatic random_config(input bit every);
    int r;
    int s;
    int e;
    int n;
    logic [63:0] lo;
    logic [63:0] hi;
    r = $urandom_range(0, 99);
    if (r < 60) s = $urandom_range(0, 3);
    else if (r < 85) s = $urandom_range(4, 20);
    else if (r < 93) s = POS_MAX;
    else s = $urandom_range(0, POS_MAX);
    r = $urandom_range(0, 99);
    if (r < 45) e = 0;
    else if (r < 75) e = s + $urandom_range(1, 24);
    else if (r < 88) e = $urandom_range((s > 0) ? 1 : 0, s);
    else if (r < 94) e = POS_MAX;
    else e = $urandom_range(0, POS_MAX);
    if (e > POS_MAX) e = POS_MAX;
    r = $urandom_range(0, 99);
    if (r < 10) n = 0;
    else if (r < 20) n = 1;
    else if (r < 32) n = phcm_pkg::MAX_PATTERN_NIBBLES_DEF;
    else if (r < 40) n = $urandom_range(phcm_pkg::MAX_PATTERN_NIBBLES_DEF + 1, 63);
    else n = $urandom_range(2, phcm_pkg::MAX_PATTERN_NIBBLES_DEF - 1);
    lo = {$urandom(), $urandom()};
    hi = {$urandom(), $urandom()};
    r = $urandom_range(0, 99);
    if (r < 8) begin
      lo = '0;
      hi = '0;
    end else if (r < 16) begin
      lo = '1;
      hi = '1;
    end
    if (every || $urandom_range(0, 99) < 60)
      write_reg(phcm_pkg::CFG_WINDOW_START, padded(s, phcm_pkg::WINDOW_BITS));
    if (every || $urandom_range(0, 99) < 60)
      write_reg(phcm_pkg::CFG_WINDOW_END, padded(e, phcm_pkg::WINDOW_BITS));
    if (every || $urandom_range(0, 99) < 60) write_reg(phcm_pkg::CFG_PATTERN_LOW, lo);
    if (every || $urandom_range(0, 99) < 60) write_reg(phcm_pkg::CFG_PATTERN_HIGH, hi);
    if (every || $urandom_range(0, 99) < 60)
      write_reg(phcm_pkg::CFG_PATTERN_LENGTH, padded(n, phcm_pkg::LENGTH_BITS));
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int rand_goal;
    int quiet_mark;
    int phase;
    int r;
    int eff;
    int plen;
    rst <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_index <= phcm_pkg::CFG_WINDOW_START;
    cfg_data <= '0;
    in_valid <= 1'b0;
    packet_byte <= '0;
    last_byte <= 1'b0;
    tx_pct = 0;
    rx_pct = 0;
    long_hold_req = 1'b0;
    bytes_sent = 0;
    cur_start = 0;
    cur_end = 0;
    cur_len = 0;
    cur_lo = '0;
    cur_hi = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // empty pattern after reset always matches
    send_byte(8'h00, 1'b1);
    settle();
    write_reg(phcm_pkg::CFG_PATTERN_LOW, 64'hAB00_0000_0000_0000);
    write_reg(phcm_pkg::CFG_PATTERN_LENGTH, 64'd2);
    write_reg(CFG_SPARE, '1);
    cfg_valid <= 1'b0;
    send_byte(8'hAB, 1'b1);
    // match starting on the low nibble of a byte
    send_byte(8'h0A, 1'b0);
    send_byte(8'hB0, 1'b1);
    send_byte(8'hBA, 1'b0);
    send_byte(8'hFF, 1'b1);
    settle();
    // pattern only outside the window, then inside it at a half-byte offset
    write_reg(phcm_pkg::CFG_WINDOW_START, 64'd1);
    write_reg(phcm_pkg::CFG_WINDOW_END, 64'd3);
    write_reg(phcm_pkg::CFG_PATTERN_LOW, 64'hFF00_0000_0000_0000);
    cfg_valid <= 1'b0;
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h0F, 1'b0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h0F, 1'b0);
    send_byte(8'hF0, 1'b1);
    settle();
    // end far past the packet
    write_reg(phcm_pkg::CFG_WINDOW_START, 64'd0);
    write_reg(phcm_pkg::CFG_WINDOW_END, '1);
    write_reg(phcm_pkg::CFG_PATTERN_LOW, 64'h1234_0000_0000_0000);
    write_reg(phcm_pkg::CFG_PATTERN_LENGTH, 64'd4);
    cfg_valid <= 1'b0;
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b1);
    settle();
    // end equal to start: empty window
    write_reg(phcm_pkg::CFG_WINDOW_START, 64'd5);
    write_reg(phcm_pkg::CFG_WINDOW_END, 64'd5);
    write_reg(phcm_pkg::CFG_PATTERN_LENGTH, 64'd0);
    cfg_valid <= 1'b0;
    send_byte(8'h55, 1'b1);
    settle();
    write_reg(phcm_pkg::CFG_PATTERN_LENGTH, 64'd4);
    cfg_valid <= 1'b0;
    send_byte(8'h55, 1'b1);
    settle();

    rand_goal = bytes_sent + RANDOM_BYTES;
    quiet_mark = bytes_sent + RANDOM_BYTES * 85 / 100;
    phase = 0;
    while (bytes_sent < rand_goal) begin
      random_config(phase == 0);
      if (bytes_sent >= quiet_mark) begin
        tx_pct = 0;
        rx_pct = 0;
      end else begin
        r = $urandom_range(0, 2);
        tx_pct = (r == 0) ? 0 : (r == 1) ? 8 : 30;
        r = $urandom_range(0, 2);
        rx_pct = (r == 0) ? 0 : (r == 1) ? 8 : 30;
      end
      if (phase == PRESSURE_PHASE) begin
        // results pile up behind the held output until input stalls
        tx_pct = 0;
        long_hold_req = 1'b1;
        repeat (40) begin
          build_packet($urandom_range(1, 3), 1'b0, 1'b0);
          send_packet();
        end
      end else begin
        repeat ($urandom_range(3, 10)) begin
          r = $urandom_range(0, 99);
          eff = (cur_len > phcm_pkg::MAX_PATTERN_NIBBLES_DEF) ?
                phcm_pkg::MAX_PATTERN_NIBBLES_DEF : cur_len;
          if (r < 70 && cur_start < 64) plen = cur_start + (eff + 1) / 2 + $urandom_range(0, 5);
          else if ($urandom_range(0, 9) == 0) plen = $urandom_range(13, 40);
          else plen = $urandom_range(1, 12);
          if (plen < 1) plen = 1;
          build_packet(plen, r < 70, r >= 55 && r < 70);
          send_packet();
        end
      end
      settle();
      phase++;
    end

    if (mismatches == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
